### rtl/core/rdd_pkg.sv
// ----------------------------------------------------------------------------
// rdd_pkg - shared types and constants of the Rice delta decoder
// Record and decode-state layouts, register indexes and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package rdd_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned REM_W    = 28;
  localparam int unsigned COUNT_W  = 24;
  localparam int unsigned K_W      = 5;
  localparam int unsigned TAKEN_W  = 5;
  localparam int unsigned LQ_W     = 4;   // ones counted inside one byte, 0..8
  localparam int unsigned BYTE_W   = 8;

  localparam logic [K_W-1:0] K_MIN = 5'd2;
  localparam logic [K_W-1:0] K_MAX = 5'd28;

  // one byte completes at most a pending value and two whole ones
  localparam int unsigned MAX_RECS   = 3;
  localparam int unsigned RECS_W     = 2;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } rdd_op_e;

  typedef enum logic [1:0] {
    CFG_RICE_PARAM  = 2'd0,
    CFG_FIRST_VALUE = 2'd1,
    CFG_ENTRY_COUNT = 2'd2
  } rdd_cfg_e;

  // decode state carried from byte to byte
  typedef struct packed {
    logic               active;
    logic               in_rem;
    logic [VALUE_W-1:0] quot;
    logic [REM_W-1:0]   rem;
    logic [TAKEN_W-1:0] taken;
    logic [COUNT_W-1:0] left;
  } rdd_state_t;

  // one result waiting to be accumulated; a start record carries the
  // first value in quot
  typedef struct packed {
    logic               start;
    logic               last;
    logic [VALUE_W-1:0] quot;
    logic [REM_W-1:0]   rem;
  } rdd_rec_t;

endpackage

`default_nettype wire

### rtl/core/rdd_bit_decoder.sv
// ----------------------------------------------------------------------------
// rdd_bit_decoder - decode one byte of the Rice bit stream
// Walks the eight bits LSB first and yields up to three finished values.
// ----------------------------------------------------------------------------
`default_nettype none

module rdd_bit_decoder (
  input  var rdd_pkg::rdd_state_t               state_i,
  input  var logic [rdd_pkg::BYTE_W-1:0]        byte_i,
  input  var logic [rdd_pkg::K_W-1:0]           k_i,
  output rdd_pkg::rdd_state_t                   state_o,
  output rdd_pkg::rdd_rec_t                     rec_o [rdd_pkg::MAX_RECS],
  output logic [rdd_pkg::RECS_W-1:0]            rec_n_o
);

  always_comb begin
    logic                           kok;
    logic                           act;
    logic                           inrem;
    logic                           base;
    logic                           base0;
    logic                           done;
    logic                           eq1;
    logic                           eq2;
    logic                           eq3;
    logic [rdd_pkg::LQ_W-1:0]       lq;
    logic [rdd_pkg::TAKEN_W-1:0]    tk;
    logic [rdd_pkg::REM_W-1:0]      rm;
    logic [rdd_pkg::RECS_W-1:0]     c;
    logic [rdd_pkg::LQ_W-1:0]       lq_slot [rdd_pkg::MAX_RECS];

    // an out-of-range k drops the byte but keeps the run as it is
    kok   = (k_i >= rdd_pkg::K_MIN) && (k_i <= rdd_pkg::K_MAX);
    act   = state_i.active;
    inrem = state_i.in_rem;
    base  = 1'b1;
    base0 = 1'b0;
    done  = 1'b0;
    lq    = '0;
    tk    = state_i.taken;
    rm    = state_i.rem;
    c     = '0;
    eq1   = (state_i.left == rdd_pkg::COUNT_W'(1));
    eq2   = (state_i.left == rdd_pkg::COUNT_W'(2));
    eq3   = (state_i.left == rdd_pkg::COUNT_W'(3));
    for (int j = 0; j < rdd_pkg::MAX_RECS; j++) begin
      rec_o[j]   = '0;
      lq_slot[j] = '0;
    end

    for (int i = 0; i < rdd_pkg::BYTE_W; i++) begin
      if (act && kok) begin
        if (!inrem) begin
          if (byte_i[i]) begin
            lq = lq + rdd_pkg::LQ_W'(1);
          end else begin
            inrem = 1'b1;
            rm    = '0;
            tk    = '0;
          end
        end else begin
          if (tk < rdd_pkg::TAKEN_W'(rdd_pkg::REM_W)) begin
            rm = rm | (rdd_pkg::REM_W'(byte_i[i]) << tk);
          end
          tk = tk + rdd_pkg::TAKEN_W'(1);
          if (tk >= k_i) begin
            // run ends once the entry counter would reach zero
            case (c)
              2'd0:    done = eq1;
              2'd1:    done = eq2;
              default: done = eq3;
            endcase
            if (c < rdd_pkg::RECS_W'(rdd_pkg::MAX_RECS)) begin
              rec_o[c].last = done;
              rec_o[c].rem  = rm;
              lq_slot[c]    = lq;
              if (c == '0) begin
                base0 = base;
              end
              c = c + rdd_pkg::RECS_W'(1);
            end
            act   = !done;
            inrem = 1'b0;
            base  = 1'b0;
            lq    = '0;
            tk    = '0;
            rm    = '0;
          end
        end
      end
    end

    // only the first finished value can extend a quotient from earlier bytes
    rec_o[0].quot = base0 ? state_i.quot + rdd_pkg::VALUE_W'(lq_slot[0])
                          : rdd_pkg::VALUE_W'(lq_slot[0]);
    for (int j = 1; j < rdd_pkg::MAX_RECS; j++) begin
      rec_o[j].quot = rdd_pkg::VALUE_W'(lq_slot[j]);
    end

    state_o.active = act;
    state_o.in_rem = inrem;
    state_o.quot   = base ? state_i.quot + rdd_pkg::VALUE_W'(lq) : rdd_pkg::VALUE_W'(lq);
    state_o.rem    = rm;
    state_o.taken  = tk;
    state_o.left   = state_i.left - rdd_pkg::COUNT_W'(c);
    rec_n_o        = c;
  end

endmodule

`default_nettype wire

### rtl/core/rdd_record_fifo.sv
// ----------------------------------------------------------------------------
// rdd_record_fifo - small queue of finished records
// Takes up to three records a cycle, hands out one a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rdd_record_fifo (
  input  var logic                              clk_i,
  input  var logic                              rst_ni,
  input  var logic [rdd_pkg::RECS_W-1:0]        push_n_i,
  input  var rdd_pkg::rdd_rec_t                 push_rec_i [rdd_pkg::MAX_RECS],
  input  var logic                              pop_i,
  output rdd_pkg::rdd_rec_t                     head_o,
  output logic                                  valid_o,
  output logic [rdd_pkg::FIFO_CW-1:0]           count_o
);

  rdd_pkg::rdd_rec_t                 mem_q [rdd_pkg::FIFO_DEPTH];
  logic [rdd_pkg::FIFO_AW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [rdd_pkg::FIFO_AW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [rdd_pkg::FIFO_CW-1:0]       count_q, count_d;

  assign wr_ptr_d = wr_ptr_q + rdd_pkg::FIFO_AW'(push_n_i);
  assign rd_ptr_d = rd_ptr_q + rdd_pkg::FIFO_AW'(pop_i);
  assign count_d  = count_q + rdd_pkg::FIFO_CW'(push_n_i) - rdd_pkg::FIFO_CW'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < rdd_pkg::MAX_RECS; j++) begin
      if (rdd_pkg::RECS_W'(j) < push_n_i) begin
        mem_q[wr_ptr_q + rdd_pkg::FIFO_AW'(j)] <= push_rec_i[j];
      end
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign count_o = count_q;

endmodule

`default_nettype wire

### rtl/core/rdd_accumulator.sv
// ----------------------------------------------------------------------------
// rdd_accumulator - running sum and result register
// Adds each delta to the sum, or reloads it from a start record, and holds the beat until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rdd_accumulator (
  input  var logic                              clk_i,
  input  var logic                              rst_ni,
  input  var logic [rdd_pkg::K_W-1:0]           k_i,
  input  var rdd_pkg::rdd_rec_t                 rec_i,
  input  var logic                              rec_valid_i,
  output logic                                  pop_o,
  input  var logic                              m_axis_tready,
  output logic                                  m_axis_tvalid,
  output logic [rdd_pkg::VALUE_W-1:0]           m_axis_tdata,
  output logic                                  m_axis_tlast
);

  logic [rdd_pkg::VALUE_W-1:0] sum_q, sum_d;
  logic [rdd_pkg::VALUE_W-1:0] delta;
  logic                        valid_q;
  logic [rdd_pkg::VALUE_W-1:0] data_q;
  logic                        last_q;

  assign pop_o = rec_valid_i && (!valid_q || m_axis_tready);
  assign delta = (rec_i.quot << k_i) + rdd_pkg::VALUE_W'(rec_i.rem);
  assign sum_d = rec_i.start ? rec_i.quot : sum_q + delta;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sum_q   <= '0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
      sum_q   <= sum_d;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= sum_d;
      last_q <= rec_i.last;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tlast  = last_q;

endmodule

`default_nettype wire

### rtl/core/rice_delta_decoder_core.sv
// ----------------------------------------------------------------------------
// rice_delta_decoder_core - Rice-coded delta list decoder
// Turns a byte stream of Rice-coded deltas into absolute 32-bit values.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Beat content
// s_axis    in         tuser: operation (0 start, 1 data); tdata: data_byte
// m_axis    out        tdata: entry_value; tlast: is_last
// cfg       in         cfg_index_i: register index; cfg_data_i: write data
//
// One byte is taken every cycle while the record queue has room; a byte that completes n
// values yields n result beats through the single result register behind the queue.
// A beat passes the input register, the record queue and the result register.
// The held byte waits in the input register while more than one record waits in the queue.
// Reset clears the run, the running sum and the queue; k resets to 2.
// Configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rice_delta_decoder_core (
  input  var logic                              clk_i,
  input  var logic                              rst_ni,
  // input stream
  input  var logic                              s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  var logic [7:0]                        s_axis_tdata,  // [7:0] data_byte
  input  var logic                              s_axis_tuser,  // [0] operation
  // result stream
  output logic                                  m_axis_tvalid,
  input  var logic                              m_axis_tready,
  output logic [31:0]                           m_axis_tdata,  // [31:0] entry_value
  output logic                                  m_axis_tlast,
  // register writes
  input  var logic                              cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  var logic [1:0]                        cfg_index_i,
  input  var logic [31:0]                       cfg_data_i
);

  // configuration registers
  logic [rdd_pkg::K_W-1:0]     k_q;
  logic [rdd_pkg::VALUE_W-1:0] first_q;
  logic [rdd_pkg::COUNT_W-1:0] count_q;

  // input register
  logic                        in_valid_q;
  logic                        in_op_q;
  logic [rdd_pkg::BYTE_W-1:0]  in_byte_q;
  logic                        in_take;
  logic                        consume;
  logic                        room;

  // decode state and records
  rdd_pkg::rdd_state_t         state_q, state_d;
  rdd_pkg::rdd_state_t         dec_state;
  rdd_pkg::rdd_rec_t           dec_rec  [rdd_pkg::MAX_RECS];
  logic [rdd_pkg::RECS_W-1:0]  dec_n;
  rdd_pkg::rdd_rec_t           push_rec [rdd_pkg::MAX_RECS];
  logic [rdd_pkg::RECS_W-1:0]  push_n;

  // queue to accumulator
  rdd_pkg::rdd_rec_t           head;
  logic                        head_valid;
  logic                        pop;
  logic [rdd_pkg::FIFO_CW-1:0] fifo_count;

  // --------------------------------------------------------------------------
  // Configuration: always ready, unknown indexes dropped
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= rdd_pkg::K_MIN;
      first_q <= '0;
      count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        rdd_pkg::CFG_RICE_PARAM:  k_q     <= cfg_data_i[rdd_pkg::K_W-1:0];
        rdd_pkg::CFG_FIRST_VALUE: first_q <= cfg_data_i;
        rdd_pkg::CFG_ENTRY_COUNT: count_q <= cfg_data_i[rdd_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register: advance when the queue can absorb a full byte's worth
  // --------------------------------------------------------------------------
  assign room          = (fifo_count <=
                          rdd_pkg::FIFO_CW'(rdd_pkg::FIFO_DEPTH - rdd_pkg::MAX_RECS));
  assign consume       = in_valid_q && room;
  assign s_axis_tready = !in_valid_q || room;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (consume) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_op_q   <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  // --------------------------------------------------------------------------
  // Bit decode of the held byte
  // --------------------------------------------------------------------------
  rdd_bit_decoder u_bit_decoder (
    .state_i (state_q),
    .byte_i  (in_byte_q),
    .k_i     (k_q),
    .state_o (dec_state),
    .rec_o   (dec_rec),
    .rec_n_o (dec_n)
  );

  // A start beat reloads the run and queues the first value; a data beat
  // takes whatever the decoder produced (nothing when idle or k is invalid).
  always_comb begin
    state_d = state_q;
    push_n  = '0;
    for (int j = 0; j < rdd_pkg::MAX_RECS; j++) begin
      push_rec[j] = dec_rec[j];
    end
    if (consume) begin
      if (in_op_q == rdd_pkg::OP_START) begin
        state_d        = '0;
        state_d.left   = count_q;
        state_d.active = (count_q != '0);
        push_rec[0]    = '0;
        push_rec[0].start = 1'b1;
        push_rec[0].last  = (count_q == '0);
        push_rec[0].quot  = first_q;
        for (int j = 1; j < rdd_pkg::MAX_RECS; j++) begin
          push_rec[j] = '0;
        end
        push_n = rdd_pkg::RECS_W'(1);
      end else begin
        state_d = dec_state;
        push_n  = dec_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // Record queue and accumulator
  // --------------------------------------------------------------------------
  rdd_record_fifo u_record_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_n_i   (push_n),
    .push_rec_i (push_rec),
    .pop_i      (pop),
    .head_o     (head),
    .valid_o    (head_valid),
    .count_o    (fifo_count)
  );

  rdd_accumulator u_accumulator (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .k_i           (k_q),
    .rec_i         (head),
    .rec_valid_i   (head_valid),
    .pop_o         (pop),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_count <= rdd_pkg::FIFO_CW'(rdd_pkg::FIFO_DEPTH))
    else $error("record queue overfilled");

  a_idle_no_records: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && (in_op_q == rdd_pkg::OP_DATA) && !state_q.active) |-> (push_n == '0))
    else $error("records produced with no active run");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((push_n != '0) && (push_rec[0].last || push_rec[1].last || push_rec[2].last))
    |=> !state_q.active)
    else $error("run still active after its last value");

  a_pop_needs_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (fifo_count != '0))
    else $error("pop from empty record queue");
`endif

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the Rice delta decoder core
// Streams start and data beats through the input port and predicts every
// decoded entry in a cycle-free model of the decoder. Each output beat is
// checked against the oldest predicted entry. Registers are rewritten between
// phases, covering valid and invalid Rice parameters and count extremes.
// ----------------------------------------------------------------------------

module testbench;

  localparam int unsigned TX_WANT      = 200;   // random input beats to send
  localparam int unsigned DRAIN_CYCLES = 10;    // margin for the pipeline to drain
  localparam int unsigned IDLE_LIMIT   = 2000;  // cycles without any beat
  localparam int unsigned REPORT_MAX   = 10;
  localparam logic [1:0]  CFG_SPARE    = 2'd3;  // index with no register behind it

  typedef struct packed {
    rdd_pkg::rdd_op_e op;
    logic [7:0]       data;
  } beat_t;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
  } entry_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] data_byte
  logic        s_axis_tuser  = 1'b0; // [0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [31:0] entry_value
  logic        m_axis_tlast;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = '0;
  logic [31:0] cfg_data_i    = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rice_delta_decoder_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Decoder model: register copies and decode state, all as after reset
  // --------------------------------------------------------------------------
  logic [rdd_pkg::K_W-1:0]     k_reg      = 5'd2;
  logic [rdd_pkg::VALUE_W-1:0] first_reg  = '0;
  logic [rdd_pkg::COUNT_W-1:0] count_reg  = '0;

  logic                        dec_active = 1'b0;
  logic                        dec_in_rem = 1'b0;
  logic [rdd_pkg::VALUE_W-1:0] dec_quot   = '0;
  logic [rdd_pkg::REM_W-1:0]   dec_rem    = '0;
  logic [rdd_pkg::TAKEN_W-1:0] dec_taken  = '0;
  logic [rdd_pkg::VALUE_W-1:0] dec_sum    = '0;
  logic [rdd_pkg::COUNT_W-1:0] dec_left   = '0;

  beat_t  beats_todo[$];   // input beats not yet presented
  entry_t entries_due[$];  // decoded entries still to come out

  int unsigned beats_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned cfg_writes    = 0;
  int unsigned mismatch_count = 0;

  // Advance the model by one accepted input beat and queue the entries it
  // completes.
  function automatic void decode_beat(input beat_t b);
    logic [rdd_pkg::VALUE_W-1:0] delta;
    int unsigned                 n;
    n = 0;
    if (b.op == rdd_pkg::OP_START) begin
      // restart: drop any half-decoded value, reload sum and count
      dec_in_rem = 1'b0;
      dec_quot   = '0;
      dec_rem    = '0;
      dec_taken  = '0;
      dec_sum    = first_reg;
      dec_left   = count_reg;
      dec_active = (count_reg != '0);
      entries_due.push_back(entry_t'{value: dec_sum, last: ~dec_active});
      return;
    end
    // no run, or k out of range: ignore the byte and keep every bit of state
    if (!dec_active || k_reg < rdd_pkg::K_MIN || k_reg > rdd_pkg::K_MAX) return;
    for (int i = 0; i < 8; i++) begin
      if (!dec_active) break;  // run over: discard the rest of the byte
      if (!dec_in_rem) begin
        if (b.data[i]) begin
          dec_quot = dec_quot + rdd_pkg::VALUE_W'(1);
        end else begin
          dec_in_rem = 1'b1;
          dec_rem    = '0;
          dec_taken  = '0;
        end
      end else begin
        if (dec_taken < rdd_pkg::TAKEN_W'(rdd_pkg::REM_W))
          dec_rem = dec_rem | (rdd_pkg::REM_W'(b.data[i]) << dec_taken);
        dec_taken = dec_taken + rdd_pkg::TAKEN_W'(1);
        // compare against the live k, so a lowered k finishes the value at once
        if (dec_taken >= k_reg) begin
          delta      = (dec_quot << k_reg) + {4'b0, dec_rem};
          dec_sum    = dec_sum + delta;
          dec_left   = dec_left - rdd_pkg::COUNT_W'(1);
          dec_in_rem = 1'b0;
          dec_quot   = '0;
          dec_rem    = '0;
          dec_taken  = '0;
          if (dec_left == '0) dec_active = 1'b0;
          if (n < rdd_pkg::MAX_RECS) begin
            entries_due.push_back(entry_t'{value: dec_sum, last: ~dec_active});
            n++;
          end
        end
      end
    end
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  // Bytes biased towards all zeros and all ones, the rest uniform.
  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: present queued beats with random gaps between them
  // --------------------------------------------------------------------------
  beat_t       beat_cur;
  int unsigned tx_gap   = 0;
  int unsigned tx_burst = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_beat(beat_cur);
        beats_sent++;
      end
      // hold the current beat until it is taken, then fetch the next one
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (beats_todo.size() != 0) begin
          beat_cur = beats_todo.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= beat_cur.op;
          s_axis_tdata  <= beat_cur.data;
          if (tx_burst != 0) begin
            tx_burst--;
          end else begin
            tx_gap = draw_gap();
            if ($urandom_range(0, 24) == 0) tx_burst = $urandom_range(16, 48);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: check each result beat, stall the output at random
  // --------------------------------------------------------------------------
  int unsigned rx_hold  = 0;
  int unsigned rx_burst = 0;

  always @(posedge clk_i) begin
    entry_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (entries_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("unexpected result %0d: value %h last %b", results_seen,
                     m_axis_tdata, m_axis_tlast);
        end else begin
          want = entries_due.pop_front();
          if (m_axis_tdata !== want.value || m_axis_tlast !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
              $display("result %0d: expected value %h last %b, got value %h last %b",
                       results_seen, want.value, want.last, m_axis_tdata, m_axis_tlast);
          end
        end
      end
      if (rx_hold != 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (rx_burst != 0) begin
          if (m_axis_tvalid && m_axis_tready) rx_burst--;
        end else if (m_axis_tvalid && m_axis_tready) begin
          // stall after a beat, so gaps land between results of one byte too
          rx_hold = draw_gap();
          if ($urandom_range(0, 24) == 0) rx_burst = $urandom_range(16, 48);
        end else if ($urandom_range(0, 19) == 0) begin
          rx_hold = $urandom_range(1, 4);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: give up when no beat moves on any channel for too long
  // --------------------------------------------------------------------------
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d entries outstanding",
               IDLE_LIMIT, entries_due.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_beat(input rdd_pkg::rdd_op_e op, input logic [7:0] data);
    beats_todo.push_back(beat_t'{op: op, data: data});
  endtask

  // Write one register and mirror it into the model; finish on a falling
  // edge so queue updates never share a step with the driver.
  task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      rdd_pkg::CFG_RICE_PARAM:  k_reg     = val[rdd_pkg::K_W-1:0];
      rdd_pkg::CFG_FIRST_VALUE: first_reg = val;
      rdd_pkg::CFG_ENTRY_COUNT: count_reg = val[rdd_pkg::COUNT_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
  endtask

  // Wait until every beat is in and every entry out, then let the pipeline
  // settle, since a byte may produce nothing.
  task automatic wait_quiet();
    do @(negedge clk_i);
    while (beats_todo.size() != 0 || s_axis_tvalid || entries_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned random_beats;
    int unsigned phases;
    int unsigned kind;
    int unsigned n;
    int unsigned r;
    logic [4:0]  kv;
    logic [23:0] cv;
    logic [31:0] fv;

    random_beats = 0;
    phases       = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset values: data with no run is dropped, a start with zero count
    // emits the first value as the last one and leaves the run idle.
    push_beat(rdd_pkg::OP_DATA, 8'hA5);
    push_beat(rdd_pkg::OP_START, 8'h3C);
    push_beat(rdd_pkg::OP_DATA, 8'h00);
    wait_quiet();

    // k = 2 with the largest sum and count: sum wraps, and the second zero
    // byte finishes a pending value plus two whole ones.
    set_reg(rdd_pkg::CFG_RICE_PARAM, 32'd2);
    set_reg(rdd_pkg::CFG_FIRST_VALUE, 32'hFFFF_FFFF);
    set_reg(rdd_pkg::CFG_ENTRY_COUNT, 32'h00FF_FFFF);
    push_beat(rdd_pkg::OP_START, 8'h00);
    push_beat(rdd_pkg::OP_DATA, 8'h00);
    push_beat(rdd_pkg::OP_DATA, 8'h00);
    push_beat(rdd_pkg::OP_DATA, 8'hFF);
    push_beat(rdd_pkg::OP_DATA, 8'hFF);
    push_beat(rdd_pkg::OP_DATA, 8'h55);
    push_beat(rdd_pkg::OP_DATA, 8'hAA);
    wait_quiet();

    // k = 28: sixteen ones shift the quotient out of 32 bits; leave the
    // next value part-way through its remainder.
    set_reg(rdd_pkg::CFG_RICE_PARAM, 32'd28);
    set_reg(rdd_pkg::CFG_FIRST_VALUE, 32'd0);
    set_reg(rdd_pkg::CFG_ENTRY_COUNT, 32'd2);
    push_beat(rdd_pkg::OP_START, 8'hFF);
    push_beat(rdd_pkg::OP_DATA, 8'hFF);
    push_beat(rdd_pkg::OP_DATA, 8'hFF);
    push_beat(rdd_pkg::OP_DATA, 8'h00);
    push_beat(rdd_pkg::OP_DATA, 8'h00);
    push_beat(rdd_pkg::OP_DATA, 8'hF0);
    push_beat(rdd_pkg::OP_DATA, 8'h00);
    wait_quiet();

    // Out-of-range k at both ends: bytes dropped, state kept. Then lower k
    // to 2 so the half-taken remainder completes on the first bit and ends
    // the run mid-byte; later bytes are dropped.
    set_reg(rdd_pkg::CFG_RICE_PARAM, 32'd0);
    push_beat(rdd_pkg::OP_DATA, 8'h00);
    wait_quiet();
    set_reg(rdd_pkg::CFG_RICE_PARAM, 32'd1);
    push_beat(rdd_pkg::OP_DATA, 8'hFF);
    wait_quiet();
    set_reg(rdd_pkg::CFG_RICE_PARAM, 32'd29);
    push_beat(rdd_pkg::OP_DATA, 8'h0F);
    wait_quiet();
    set_reg(rdd_pkg::CFG_RICE_PARAM, 32'd31);
    push_beat(rdd_pkg::OP_DATA, 8'hF0);
    wait_quiet();
    set_reg(rdd_pkg::CFG_RICE_PARAM, 32'd2);
    push_beat(rdd_pkg::OP_DATA, 8'h00);
    push_beat(rdd_pkg::OP_DATA, 8'h12);
    wait_quiet();

    // Single-entry runs and a restart; also poke the unused index.
    set_reg(CFG_SPARE, 32'hDEAD_BEEF);
    set_reg(rdd_pkg::CFG_RICE_PARAM, 32'd3);
    set_reg(rdd_pkg::CFG_FIRST_VALUE, 32'h1234_5678);
    set_reg(rdd_pkg::CFG_ENTRY_COUNT, 32'd1);
    push_beat(rdd_pkg::OP_START, 8'h00);
    push_beat(rdd_pkg::OP_DATA, 8'h01);
    push_beat(rdd_pkg::OP_START, 8'hC3);
    push_beat(rdd_pkg::OP_DATA, 8'h00);
    wait_quiet();

    // Random phases: mostly a start followed by bytes, some phases that
    // carry on an unfinished run, a few of pure noise.
    while (random_beats < TX_WANT) begin
      phases++;
      r = $urandom_range(0, 9);
      if (r < 6)       kv = 5'($urandom_range(2, 8));
      else if (r < 8)  kv = 5'($urandom_range(9, 28));
      else if (r == 8) kv = ($urandom_range(0, 1) != 0) ? 5'd2 : 5'd28;
      else begin
        case ($urandom_range(0, 4))
          0:       kv = 5'd0;
          1:       kv = 5'd1;
          2:       kv = 5'd29;
          3:       kv = 5'd30;
          default: kv = 5'd31;
        endcase
      end
      r = $urandom_range(0, 9);
      if (r < 7)       cv = 24'($urandom_range(1, 12));
      else if (r == 7) cv = 24'd0;
      else if (r == 8) cv = 24'hFF_FFFF;
      else             cv = 24'($urandom);
      r = $urandom_range(0, 9);
      if (r == 0)      fv = 32'd0;
      else if (r == 1) fv = 32'hFFFF_FFFF;
      else             fv = $urandom;
      // upper data bits beyond each register's width are random
      if ($urandom_range(0, 3) != 0)
        set_reg(rdd_pkg::CFG_RICE_PARAM, {27'($urandom), kv});
      if ($urandom_range(0, 2) != 0) set_reg(rdd_pkg::CFG_FIRST_VALUE, fv);
      if ($urandom_range(0, 2) != 0)
        set_reg(rdd_pkg::CFG_ENTRY_COUNT, {8'($urandom), cv});

      kind = $urandom_range(0, 9);
      n    = $urandom_range(2, 12);
      if (kind < 7) begin
        push_beat(rdd_pkg::OP_START, 8'($urandom));
        for (int i = 0; i < n; i++) push_beat(rdd_pkg::OP_DATA, pick_byte());
        random_beats += n + 1;
      end else if (kind < 9) begin
        for (int i = 0; i < n; i++) push_beat(rdd_pkg::OP_DATA, pick_byte());
        random_beats += n;
      end else begin
        for (int i = 0; i < n; i++)
          push_beat(($urandom_range(0, 3) == 0) ? rdd_pkg::OP_START : rdd_pkg::OP_DATA,
                    8'($urandom));
        random_beats += n;
      end
      wait_quiet();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("ran %0d random phases: %0d input beats, %0d register writes",
             phases, beats_sent, cfg_writes);
    $display("checked %0d result beats, %0d mismatches", results_seen, mismatch_count);
    if (mismatch_count == 0 && entries_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
